FILE: sv/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Item layouts, operation and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package pol_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Field widths fixed by the item layouts
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Internal widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK     = 3'd0,
    OP_PUSH_FRONT   = 3'd1,
    OP_INSERT_AT    = 3'd2,
    OP_REMOVE_FRONT = 3'd3,
    OP_REMOVE_BACK  = 3'd4,
    OP_REMOVE_AT    = 3'd5,
    OP_FIND         = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Where an insert or remove takes place
  typedef enum logic [1:0] {
    AT_ZERO  = 2'd0,
    AT_COUNT = 2'd1,
    AT_LAST  = 2'd2,
    AT_POS   = 2'd3
  } at_sel_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    insert;
    logic    remove;
    logic    find;
    at_sel_t at_sel;
    status_t status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_le_cnt;
    logic pos_lt_cnt;
  } dp_stat_t;

endpackage

FILE: sv/pol_dp.sv
// ----------------------------------------------------------------------------
// pol_dp: list datapath
// Row of entry cells that shift to open or close a gap, per-cell key
// compare, entry count and the result register.
// ----------------------------------------------------------------------------
module pol_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pol_pkg::in_item_t  in_item,
  input  pol_pkg::dp_cmd_t   cmd,
  output pol_pkg::dp_stat_t  stat,
  output pol_pkg::out_item_t out_item
);
  import pol_pkg::*;

  logic [DATA_WIDTH-1:0] entries_r   [DEPTH];
  logic [DATA_WIDTH-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  out_item_t             res_r, res_nxt;
  logic [CNT_W-1:0]      at;
  logic [DEPTH-1:0]      hit;

  // Capture position and word of the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= in_item.position;
      word_r <= DATA_WIDTH'(in_item.value);
    end
  end

  // Flags for the controller
  always_comb begin
    stat.empty      = (count_r == '0);
    stat.full       = (count_r == CNT_W'(DEPTH));
    stat.pos_le_cnt = (CMP_W'(pos_r) <= CMP_W'(count_r));
    stat.pos_lt_cnt = (CMP_W'(pos_r) <  CMP_W'(count_r));
  end

  // Resolve the cell index of the operation
  always_comb begin
    unique case (cmd.at_sel)
      AT_ZERO:  at = '0;
      AT_COUNT: at = count_r;
      AT_LAST:  at = count_r - 1'b1;
      AT_POS:   at = CNT_W'(pos_r);
      default:  at = '0;
    endcase
  end

  // Each cell takes its neighbor, the new word, or holds
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
      if (cmd.exec && cmd.insert) begin
        if (i > 0 && CNT_W'(i) > at) begin
          entries_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
        end else if (CNT_W'(i) == at) begin
          entries_nxt[i] = word_r;
        end
      end else if (cmd.exec && cmd.remove) begin
        if (i < DEPTH - 1 && CNT_W'(i) >= at) begin
          entries_nxt[i] = entries_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
  end

  // Per-cell key compare, live entries only
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < count_r) && (entries_r[i] == word_r);
    end
  end

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.exec && cmd.remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Build the result item
  always_comb begin
    res_nxt.status = cmd.status;
    res_nxt.found  = cmd.find && (|hit);
    res_nxt.count  = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  assign out_item = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.insert) |-> !stat.full)
    else $error("insert into full list");

  a_remove_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.remove) |-> !stat.empty)
    else $error("remove from empty list");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.insert) |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not advance count");

endmodule

FILE: sv/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl: list controller
// Accepts an item, decodes its operation against the list flags, issues
// one execute command and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [pol_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  pol_pkg::dp_stat_t        stat,
  output pol_pkg::dp_cmd_t         cmd
);
  import pol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [OP_W-1:0] op_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // Hold the operation code of the accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_op;
    end
  end

  // Sequence: accept, execute, deliver
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RESP;
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the operation into a datapath command
  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.exec   = (state_r == S_EXEC);
    cmd.at_sel = AT_ZERO;
    cmd.status = ST_IGNORED;
    unique case (op_r)
      OP_ADD_BACK: begin
        cmd.at_sel = AT_COUNT;
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status = ST_DONE;
          cmd.insert = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status = ST_DONE;
          cmd.insert = 1'b1;
        end
      end
      OP_INSERT_AT: begin
        cmd.at_sel = AT_POS;
        if (!stat.pos_le_cnt) begin
          cmd.status = ST_IGNORED;
        end else if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status = ST_DONE;
          cmd.insert = 1'b1;
        end
      end
      OP_REMOVE_FRONT: begin
        if (!stat.empty) begin
          cmd.status = ST_DONE;
          cmd.remove = 1'b1;
        end
      end
      OP_REMOVE_BACK: begin
        cmd.at_sel = AT_LAST;
        if (!stat.empty) begin
          cmd.status = ST_DONE;
          cmd.remove = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        cmd.at_sel = AT_POS;
        if (stat.pos_lt_cnt) begin
          cmd.status = ST_DONE;
          cmd.remove = 1'b1;
        end
      end
      OP_FIND: begin
        cmd.status = ST_DONE;
        cmd.find   = 1'b1;
      end
      default: cmd.status = ST_IGNORED;
    endcase
  end

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $past(in_valid && in_ready))
    else $error("execute without an accepted item");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.remove, cmd.find}))
    else $error("more than one list action decoded");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

endmodule

FILE: sv/positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_core: bounded ordered list with positional access
// Push/remove at either end or at a position, and key search, over a row
// of DEPTH entry cells. One result item per input item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid / in_ready   | in_item  {op, position, value}
//   out     | output    | out_valid / out_ready | out_item {status, found, count}
//
// A result is offered in the deliver state that follows the execute state
// of the cell row, and can be taken at the following edge. The
// controller handles one item at a time, so the next item is accepted only
// after the result is taken and the controller is back in its idle state.
// Reset clears the entry count and the controller; entry cells need none.
// A stalled result holds the output and keeps in_ready low.
module positional_ordered_list_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pol_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pol_pkg::out_item_t out_item
);
  import pol_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_item.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pol_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_ordered_list_core
// Drives list operations through the valid/ready input channel, predicts the
// status, found flag and count of every item from a local copy of the list,
// and compares each result item in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import pol_pkg::*;

  // Op code with no operation behind it
  localparam logic [OP_W-1:0] OP_NONE = 3'd7;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Local copy of the list, updated as each item is accepted
  logic [DATA_WIDTH-1:0] list_words [DEPTH];
  int                    list_len;

  out_item_t pending_results [$];
  int        mismatches;
  int        results_seen;
  int        cycle_count;
  bit        quiet;

  positional_ordered_list_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic status_t list_insert(int at, logic [DATA_WIDTH-1:0] word);
    if (at > list_len) return ST_IGNORED;
    if (list_len >= DEPTH) return ST_FULL;
    for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic status_t list_remove(int at);
    if (list_len == 0 || at >= list_len) return ST_IGNORED;
    for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return ST_DONE;
  endfunction

  // Apply one operation to the local list and return the expected result
  function automatic out_item_t apply_list_op(in_item_t item);
    out_item_t res;
    status_t   st;
    logic      hit;
    st  = ST_IGNORED;
    hit = 1'b0;
    case (item.op)
      OP_ADD_BACK:     st = list_insert(list_len, item.value[DATA_WIDTH-1:0]);
      OP_PUSH_FRONT:   st = list_insert(0, item.value[DATA_WIDTH-1:0]);
      OP_INSERT_AT:    st = list_insert(int'(item.position), item.value[DATA_WIDTH-1:0]);
      OP_REMOVE_FRONT: st = list_remove(0);
      OP_REMOVE_BACK:  st = (list_len == 0) ? ST_IGNORED : list_remove(list_len - 1);
      OP_REMOVE_AT:    st = list_remove(int'(item.position));
      OP_FIND: begin
        st = ST_DONE;
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == item.value[DATA_WIDTH-1:0]) hit = 1'b1;
      end
      default:         st = ST_IGNORED;
    endcase
    res.status = st;
    res.found  = hit;
    res.count  = list_len[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Offer one item after a random gap, hold it until accepted, then predict
  task automatic send_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] value);
    in_item_t item;
    int       gap;
    item.op       = op;
    item.position = pos;
    item.value    = value;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      in_item  = {OP_W'($urandom), POS_W'($urandom), VALUE_W'($urandom)};
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = item;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), apply_list_op(item));
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return VALUE_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // Mostly well-formed operations, biased to grow or shrink; the rest noise
  task automatic send_random_op(int grow_pct);
    logic [OP_W-1:0]    op;
    int                 pos;
    logic [VALUE_W-1:0] word;
    word = pick_word();
    pos  = $urandom_range(0, 31);
    if ($urandom_range(0, 99) < 15) begin
      op   = OP_W'($urandom_range(0, 7));
      word = $urandom;
    end else if ($urandom_range(0, 99) < 15) begin
      op = OP_FIND;
      if (list_len > 0 && $urandom_range(0, 9) < 6)
        word = list_words[$urandom_range(0, list_len - 1)];
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0: op = OP_ADD_BACK;
        1: op = OP_PUSH_FRONT;
        default: begin
          op = OP_INSERT_AT;
          if ($urandom_range(0, 4) != 0) pos = $urandom_range(0, list_len);
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: op = OP_REMOVE_FRONT;
        1: op = OP_REMOVE_BACK;
        default: begin
          op = OP_REMOVE_AT;
          if (list_len > 0 && $urandom_range(0, 4) != 0)
            pos = $urandom_range(0, list_len - 1);
        end
      endcase
    end
    send_list_op(op, pos[POS_W-1:0], word);
  endtask

  // Drop valid before the block is ready again, then wait for every result
  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Removes, find and an out-of-range insert on an empty list, plus the no-operation code
  task automatic test_empty_list();
    send_list_op(OP_REMOVE_FRONT, 0, 32'h0);
    send_list_op(OP_REMOVE_BACK, 0, 32'h0);
    send_list_op(OP_REMOVE_AT, 0, 32'h0);
    send_list_op(OP_FIND, 0, 32'h0);
    send_list_op(OP_NONE, 5'd31, 32'hFFFF_FFFF);
    send_list_op(OP_INSERT_AT, 1, 32'h1234_5678);
  endtask

  // Fill through every insert flavor, then hit the full and out-of-range cases
  task automatic test_fill_and_full();
    int n;
    n = 0;
    send_list_op(OP_INSERT_AT, 0, 32'h0);
    send_list_op(OP_ADD_BACK, 0, 32'hFFFF_FFFF);
    send_list_op(OP_INSERT_AT, list_len[POS_W-1:0], 32'h8000_0001);
    send_list_op(OP_INSERT_AT, 1, 32'h7FFF_FFFE);
    while (list_len < DEPTH) begin
      if (n[0]) send_list_op(OP_PUSH_FRONT, 0, 32'h100 + n);
      else send_list_op(OP_ADD_BACK, 0, 32'h200 + n);
      n++;
    end
    send_list_op(OP_ADD_BACK, 0, 32'h1);
    send_list_op(OP_PUSH_FRONT, 0, 32'h2);
    send_list_op(OP_INSERT_AT, 5, 32'h3);
    send_list_op(OP_INSERT_AT, 16, 32'h4);
    send_list_op(OP_INSERT_AT, 17, 32'h5);
    send_list_op(OP_INSERT_AT, 31, 32'h6);
  endtask

  // Find hit and miss, then removes at both ends, the last slot and out of range
  task automatic test_find_and_remove();
    send_list_op(OP_FIND, 0, 32'hFFFF_FFFF);
    send_list_op(OP_FIND, 0, 32'h5A5A_5A5A);
    send_list_op(OP_REMOVE_AT, list_len[POS_W-1:0] - 1'b1, 32'h0);
    send_list_op(OP_REMOVE_AT, 3, 32'h0);
    send_list_op(OP_REMOVE_AT, list_len[POS_W-1:0], 32'h0);
    send_list_op(OP_REMOVE_AT, 31, 32'h0);
    send_list_op(OP_REMOVE_FRONT, 0, 32'h0);
    send_list_op(OP_REMOVE_BACK, 0, 32'h0);
  endtask

  // Short bursts, each followed by a full drain before the next one
  task automatic test_pause_until_drained();
    for (int b = 0; b < 4; b++) begin
      repeat (8) send_random_op(60);
      wait_all_results();
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // No gaps on either side
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (60) send_random_op(55);
    quiet = 1'b0;
  endtask

  // Random growing, shrinking and balanced phases so the list swings between empty and full
  task automatic test_random_traffic(int n_items);
    int left;
    int grow_pct;
    left = 0;
    grow_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (left == 0) begin
        left = $urandom_range(10, 50);
        case ($urandom_range(0, 2))
          0:       grow_pct = 85;
          1:       grow_pct = 20;
          default: grow_pct = 50;
        endcase
      end
      left--;
      send_random_op(grow_pct);
    end
  endtask

  // Result side: ready high for a random run, then an optional stall
  initial begin : result_sink
    int run;
    int hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_ready = 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Compare each taken result against the oldest prediction
  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item.status, want.status));
          if (out_item.found !== want.found)
            report_mismatch($sformatf("found %0d, expected %0d",
                                      out_item.found, want.found));
          if (out_item.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_item.count, want.count));
        end
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : main
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    quiet        = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    list_len     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_and_full();
    test_find_and_remove();
    test_pause_until_drained();
    test_back_to_back();
    test_random_traffic(1820);

    // Drop valid, drain the results, then let the pipeline settle
    @(negedge clk);
    in_valid = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
